// ----- design/i2p_pkg.sv -----
// Package for the infix-to-postfix converter.
// Holds controller states, command/status structs, character codes and classifiers.
// No dependencies.
package i2p_pkg;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam logic [1:0] PREC_POW  = 2'd3;
    localparam logic [1:0] PREC_MUL  = 2'd2;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_NONE = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept_en;
        logic load;
        logic rd;
        logic pop;
        logic discard;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_operand;
        logic in_scan;
        logic cnt_nz;
        logic cnt_gt1;
        logic pop_ok;
        logic rpar_item;
        logic end_item;
        logic pend_valid;
        logic out_free;
    } t_sts;

    function automatic logic [1:0] prec_of(input logic [7:0] ch);
        logic [1:0] p;
        if (ch == CH_CARET) begin
            p = PREC_POW;
        end else if (ch == CH_STAR || ch == CH_SLASH) begin
            p = PREC_MUL;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            p = PREC_ADD;
        end else begin
            p = PREC_NONE;
        end
        return p;
    endfunction

    function automatic logic is_operand(input logic [7:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
               (ch >= 8'h30 && ch <= 8'h39);
    endfunction

endpackage

// ----- design/i2p_if.sv -----
// Valid/ready channel interfaces for the infix-to-postfix converter.
// Depends on nothing; used by the datapath and the top level.
interface i2p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_end;

    modport source (output valid, output in_char, output is_end, input ready);
    modport sink   (input valid, input in_char, input is_end, output ready);
endinterface

interface i2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_of_run;
    logic       expression_done;
    logic       overflowed;

    modport source (output valid, output out_char, output char_valid, output last_of_run,
                    output expression_done, output overflowed, input ready);
    modport sink   (input valid, input out_char, input char_valid, input last_of_run,
                    input expression_done, input overflowed, output ready);
endinterface

// ----- design/i2p_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/i2p_ctrl.sv -----
// Controller state machine for the infix-to-postfix converter.
// Depends on i2p_pkg; drives datapath commands from datapath status.
module i2p_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  i2p_pkg::t_sts i_sts,
    output i2p_pkg::t_cmd o_cmd
);
    i2p_pkg::t_state r_state;
    i2p_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2p_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2p_pkg::ST_IDLE: begin
                if (i_sts.in_valid) begin
                    if (!i_sts.in_operand && i_sts.in_scan && i_sts.cnt_nz) begin
                        n_state = i2p_pkg::ST_EVAL;
                    end else begin
                        n_state = i2p_pkg::ST_FIN;
                    end
                end
            end
            i2p_pkg::ST_EVAL: begin
                if (i_sts.pop_ok) begin
                    if (!(i_sts.pend_valid && !i_sts.out_free) && !i_sts.cnt_gt1) begin
                        n_state = i2p_pkg::ST_FIN;
                    end
                end else begin
                    n_state = i2p_pkg::ST_FIN;
                end
            end
            i2p_pkg::ST_FIN: begin
                if (!((i_sts.pend_valid || i_sts.end_item) && !i_sts.out_free)) begin
                    n_state = i2p_pkg::ST_IDLE;
                end
            end
            default: n_state = i2p_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            i2p_pkg::ST_IDLE: begin
                o_cmd.accept_en = 1'b1;
                o_cmd.load      = i_sts.in_valid;
                o_cmd.rd        = i_sts.in_valid && !i_sts.in_operand && i_sts.in_scan &&
                                  i_sts.cnt_nz;
            end
            i2p_pkg::ST_EVAL: begin
                if (i_sts.pop_ok) begin
                    if (!(i_sts.pend_valid && !i_sts.out_free)) begin
                        o_cmd.pop = 1'b1;
                        o_cmd.rd  = i_sts.cnt_gt1;
                    end
                end else begin
                    o_cmd.discard = i_sts.rpar_item;
                end
            end
            i2p_pkg::ST_FIN: begin
                o_cmd.fin = !((i_sts.pend_valid || i_sts.end_item) && !i_sts.out_free);
            end
            default: o_cmd = '0;
        endcase
    end
endmodule

// ----- design/i2p_datapath.sv -----
// Datapath for the infix-to-postfix converter: item registers, stack count,
// operator stack RAM, pending result and output register.
// Depends on i2p_pkg, i2p_if and i2p_ram.
module i2p_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2p_in_if.sink        i_in,
    i2p_out_if.source     o_out,
    input  i2p_pkg::t_cmd i_cmd,
    output i2p_pkg::t_sts o_sts
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0]    r_ch;
    logic          r_end;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_pv, n_pv;
    logic [7:0]    r_pch, n_pch;
    logic          r_ov, n_ov;
    logic [7:0]    r_och, n_och;
    logic          r_ocv, n_ocv;
    logic          r_olast, n_olast;
    logic          r_odone, n_odone;
    logic          r_oovf, n_oovf;

    logic [7:0]    rdata;
    logic [CW-1:0] rd_ptr;
    logic          push_item;
    logic          full;
    logic          we;
    logic          emit;
    logic          out_free;
    logic [1:0]    top_prec;
    logic [1:0]    cur_prec;
    logic          pop_ok;

    assign push_item = !r_end && !i2p_pkg::is_operand(r_ch) && (r_ch != i2p_pkg::CH_RPAREN);
    assign full      = (r_cnt == CW'(STACK_DEPTH));
    assign we        = i_cmd.fin && push_item && !full;
    assign rd_ptr    = i_cmd.pop ? (r_cnt - CW'(2)) : (r_cnt - CW'(1));
    assign out_free  = !r_ov || o_out.ready;

    i2p_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(r_ch),
        .i_re   (i_cmd.rd),
        .i_raddr(rd_ptr[AW-1:0]),
        .o_rdata(rdata)
    );

    assign top_prec = i2p_pkg::prec_of(rdata);
    assign cur_prec = i2p_pkg::prec_of(r_ch);

    always_comb begin
        priority if (r_end) begin
            pop_ok = 1'b1;
        end else if (rdata == i2p_pkg::CH_LPAREN) begin
            pop_ok = 1'b0;
        end else if (r_ch == i2p_pkg::CH_RPAREN) begin
            pop_ok = 1'b1;
        end else if (r_ch == i2p_pkg::CH_CARET) begin
            pop_ok = top_prec > cur_prec;
        end else begin
            pop_ok = top_prec >= cur_prec;
        end
    end

    assign emit = (i_cmd.pop && r_pv) || (i_cmd.fin && (r_pv || r_end));

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        n_pv  = r_pv;
        n_pch = r_pch;
        if (i_cmd.load) begin
            n_pv  = !i_in.is_end && i2p_pkg::is_operand(i_in.in_char);
            n_pch = i_in.in_char;
        end
        if (i_cmd.pop) begin
            n_cnt = r_cnt - CW'(1);
            n_pv  = 1'b1;
            n_pch = rdata;
        end
        if (i_cmd.discard) begin
            n_cnt = r_cnt - CW'(1);
        end
        if (i_cmd.fin) begin
            n_pv = 1'b0;
            if (we) begin
                n_cnt = r_cnt + CW'(1);
            end
            if (push_item && full) begin
                n_ovf = 1'b1;
            end
            if (r_end) begin
                n_ovf = 1'b0;
            end
        end
    end

    always_comb begin
        n_ov    = r_ov && !o_out.ready;
        n_och   = r_och;
        n_ocv   = r_ocv;
        n_olast = r_olast;
        n_odone = r_odone;
        n_oovf  = r_oovf;
        if (emit) begin
            n_ov    = 1'b1;
            n_ocv   = r_pv;
            n_och   = r_pv ? r_pch : 8'h00;
            n_olast = i_cmd.fin;
            n_odone = i_cmd.fin && r_end;
            n_oovf  = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
            r_pv  <= n_pv;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch  <= i_in.in_char;
            r_end <= i_in.is_end;
        end
        r_pch   <= n_pch;
        r_och   <= n_och;
        r_ocv   <= n_ocv;
        r_olast <= n_olast;
        r_odone <= n_odone;
        r_oovf  <= n_oovf;
    end

    assign i_in.ready            = i_cmd.accept_en;
    assign o_out.valid           = r_ov;
    assign o_out.out_char        = r_och;
    assign o_out.char_valid      = r_ocv;
    assign o_out.last_of_run     = r_olast;
    assign o_out.expression_done = r_odone;
    assign o_out.overflowed      = r_oovf;

    assign o_sts.in_valid   = i_in.valid;
    assign o_sts.in_operand = !i_in.is_end && i2p_pkg::is_operand(i_in.in_char);
    assign o_sts.in_scan    = i_in.is_end || (i_in.in_char != i2p_pkg::CH_LPAREN);
    assign o_sts.cnt_nz     = (r_cnt != '0);
    assign o_sts.cnt_gt1    = (r_cnt > CW'(1));
    assign o_sts.pop_ok     = pop_ok;
    assign o_sts.rpar_item  = !r_end && (r_ch == i2p_pkg::CH_RPAREN);
    assign o_sts.end_item   = r_end;
    assign o_sts.pend_valid = r_pv;
    assign o_sts.out_free   = out_free;
endmodule

// ----- design/infix_to_postfix_converter.sv -----
// Channel    Dir  Fields                                                    Handshake
// i_in       in   in_char[7:0], is_end                                      valid/ready
// o_out      out  out_char[7:0], char_valid, last_of_run, expression_done,  valid/ready
//                 overflowed
// One item at a time: no stack scan is needed for an operand, '(' or an empty stack;
// otherwise a scan pops entries until it stops on an entry that stays, on the '(' that ')'
// discards, or on the last entry, one stack read per cycle while the output is not stalled.
// Results leave through an output register; a stalled output holds the pop loop.
// Reset is synchronous, active low; it empties the stack and clears the overflow flag.
// Top level of the infix-to-postfix converter; depends on i2p_pkg, i2p_if,
// i2p_ram, i2p_ctrl and i2p_datapath.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2p_in_if.sink    i_in,
    i2p_out_if.source o_out
);
    i2p_pkg::t_cmd cmd;
    i2p_pkg::t_sts sts;

    i2p_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    i2p_datapath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .o_out  (o_out),
        .i_cmd  (cmd),
        .o_sts  (sts)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while another is in progress");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> i_in.ready)
        else $error("controller did not return to idle after finishing");

    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.char_valid) |->
            (o_out.expression_done && o_out.last_of_run && o_out.out_char == 8'h00))
        else $error("result without character outside an empty flush");

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pop && sts.pend_valid) |=> o_out.valid && !o_out.last_of_run)
        else $error("popped result lost or marked last");
`endif
endmodule
